### rtl/modbus_tcp_read_response_parser_assert.svh
// assertion macros for the modbus tcp read response parser
`ifndef MODBUS_TCP_READ_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_TCP_READ_RESPONSE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTRP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtrp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MTRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtrp assertion failed");

`endif

### rtl/mtrp_pkg.sv
// shared types and constants for the modbus tcp read response parser
package mtrp_pkg;

    localparam int unsigned MAX_QUANTITY = 125;
    localparam int unsigned HEADER_LEN   = 9;
    localparam int unsigned FC_POS       = 7;
    localparam int unsigned COUNT_POS    = 8;
    localparam int unsigned POS_MAX      = 511;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_EXCEPTION  = 3'd2,
        ST_LENGTH     = 3'd3,
        ST_DATA_SHORT = 3'd4
    } status_t;

    typedef enum logic {
        CFG_EXPECTED_FUNCTION = 1'b0,
        CFG_REGISTER_QUANTITY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [8:0] byte_position;
        logic       function_matched;
        logic [7:0] declared_count;
        logic [7:0] high_byte_hold;
        logic [6:0] values_emitted;
    } parse_state_t;

    typedef struct packed {
        logic        value_valid;
        logic [15:0] reg_value;
        logic [6:0]  reg_index;
        logic        frame_done;
        status_t     status;
        logic [7:0]  exception_code;
    } result_t;

endpackage

### rtl/mtrp_if.sv
// word channels: frame bytes in, results out, configuration writes
interface mtrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface mtrp_out_if;
    logic              valid;
    logic              ready;
    logic              value_valid;
    logic [15:0]       reg_value;
    logic [6:0]        reg_index;
    logic              frame_done;
    mtrp_pkg::status_t status;
    logic [7:0]        exception_code;

    modport source (output valid, output value_valid, output reg_value, output reg_index,
                    output frame_done, output status, output exception_code, input ready);
    modport sink (input valid, input value_valid, input reg_value, input reg_index,
                  input frame_done, input status, input exception_code, output ready);
endinterface

interface mtrp_cfg_if;
    logic                   valid;
    logic                   ready;
    mtrp_pkg::cfg_index_t   index;
    logic [7:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/modbus_tcp_read_response_parser.sv
// top level of the modbus tcp read response parser
// Takes a register-read response one byte per word and gives one result word
// for each byte that completes a big-endian register value or is the last
// byte of a frame; the word for the last byte carries the status. A new byte
// is taken every clock cycle unless the result register is held by
// back-pressure; each byte passes through the input register, where the
// per-byte step logic works on it, and then its word lands in the result
// register. frame_in.ready follows result_out.ready in the same cycle when a
// result word is waiting and the held byte makes one too. Values are given
// speculatively: keep them only when the frame's closing status is ok.
// Configuration writes take effect at once and are meant to happen between
// frames with nothing in flight; cfg.ready is always high.
module modbus_tcp_read_response_parser (
    input  logic             clk,
    input  logic             rst_n,
    mtrp_cfg_if.sink         cfg,
    mtrp_in_if.sink          frame_in,
    mtrp_out_if.source       result_out
);
    import mtrp_pkg::*;

    `include "modbus_tcp_read_response_parser_assert.svh"

    // configuration registers
    logic [7:0] expected_function_reg;
    logic [6:0] register_quantity_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state and result register
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_result;
    logic         has_result;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_data_reg;
    logic         advance;

    // config port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_function_reg <= 8'd3;
            register_quantity_reg <= 7'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_EXPECTED_FUNCTION: expected_function_reg <= cfg.data;
                CFG_REGISTER_QUANTITY: register_quantity_reg <= cfg.data[6:0];
                default:               ;
            endcase
        end
    end

    mtrp_step u_step (
        .state             (state_reg),
        .frame_byte        (in_byte_reg),
        .frame_last        (in_last_reg),
        .expected_function (expected_function_reg),
        .register_quantity (register_quantity_reg),
        .state_next        (state_next),
        .result            (step_result),
        .has_result        (has_result)
    );

    // a byte leaves the input register when its result word has room,
    // or right away when it makes no result word
    assign advance = in_valid_reg && (!out_valid_reg || result_out.ready || !has_result);

    // input register refills whenever it empties
    assign frame_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame_in.ready)
        begin
            in_valid_reg <= frame_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            in_byte_reg <= frame_in.frame_byte;
            in_last_reg <= frame_in.frame_last;
        end
    end

    // parser state moves one byte at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_data_reg <= step_result;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.value_valid    = out_data_reg.value_valid;
    assign result_out.reg_value      = out_data_reg.reg_value;
    assign result_out.reg_index      = out_data_reg.reg_index;
    assign result_out.frame_done     = out_data_reg.frame_done;
    assign result_out.status         = out_data_reg.status;
    assign result_out.exception_code = out_data_reg.exception_code;

    // the last byte of a frame always leaves the parser state cleared
    `MTRP_ASSERT_NEXT(a_clear_after_last, advance && in_last_reg, state_reg == '0)

    // status and exception code only on the closing word
    `MTRP_ASSERT_SAME(a_status_only_done, out_valid_reg && !out_data_reg.frame_done,
        out_data_reg.status == ST_OK && out_data_reg.exception_code == 8'd0)

    // every result word carries a value or closes a frame
    `MTRP_ASSERT_SAME(a_word_has_content, out_valid_reg,
        out_data_reg.value_valid || out_data_reg.frame_done)

endmodule

### rtl/mtrp_step.sv
// per-byte parse step: next parser state and the result word for one byte
module mtrp_step (
    input  mtrp_pkg::parse_state_t state,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_last,
    input  logic [7:0]             expected_function,
    input  logic [6:0]             register_quantity,
    output mtrp_pkg::parse_state_t state_next,
    output mtrp_pkg::result_t      result,
    output logic                   has_result
);
    import mtrp_pkg::*;

    logic [6:0] qty;
    logic [7:0] need_bytes;
    logic       emit;
    parse_state_t upd;

    always_comb
    begin
        qty        = (register_quantity > 7'(MAX_QUANTITY)) ? 7'(MAX_QUANTITY)
                                                            : register_quantity;
        need_bytes = {qty, 1'b0};
        upd        = state;
        emit       = 1'b0;
        result     = '0;

        if (state.byte_position == 9'(FC_POS))
        begin
            upd.function_matched = (frame_byte == expected_function);
        end
        else if (state.byte_position == 9'(COUNT_POS))
        begin
            upd.declared_count = frame_byte;
        end
        else if (state.byte_position >= 9'(HEADER_LEN))
        begin
            // odd position is the high byte of a pair
            if (state.byte_position[0])
            begin
                upd.high_byte_hold = frame_byte;
            end
            else if (state.function_matched && (state.declared_count >= need_bytes)
                     && (state.values_emitted < qty))
            begin
                emit               = 1'b1;
                upd.values_emitted = state.values_emitted + 7'd1;
            end
        end

        if (state.byte_position != 9'(POS_MAX))
        begin
            upd.byte_position = state.byte_position + 9'd1;
        end

        if (emit)
        begin
            result.value_valid = 1'b1;
            result.reg_value   = {state.high_byte_hold, frame_byte};
            result.reg_index   = state.values_emitted;
        end

        if (frame_last)
        begin
            result.frame_done = 1'b1;
            priority if (state.byte_position < 9'(COUNT_POS))
            begin
                result.status = ST_SHORT;
            end
            else if (!upd.function_matched)
            begin
                result.status         = ST_EXCEPTION;
                result.exception_code = upd.declared_count;
            end
            else if (state.byte_position != (9'(COUNT_POS) + {1'b0, upd.declared_count}))
            begin
                result.status = ST_LENGTH;
            end
            else if (upd.declared_count < need_bytes)
            begin
                result.status = ST_DATA_SHORT;
            end
            else
            begin
                result.status = ST_OK;
            end
        end

        state_next = frame_last ? parse_state_t'('0) : upd;
        has_result = emit || frame_last;
    end

endmodule
